/* sv/qte_pkg.sv */
package qte_pkg;

    // Field widths of the external requests and results.
    localparam int QUAT_WIDTH  = 16;
    localparam int ANGLE_WIDTH = 16;

    // Internal datapath widths.
    localparam int COMP_W   = 16;   // component after input reduction
    localparam int PROD_W   = 32;   // one component product
    localparam int SUM_W    = 35;   // matrix entry before block scaling
    localparam int ENTRY_W  = 32;   // matrix entry after block scaling
    localparam int NORM_W   = 30;   // squared norm after block scaling
    localparam int ROOT_W   = 30;   // square root of the column magnitude
    localparam int SQ_W     = 62;   // squared magnitude and root remainder
    localparam int TURN_W   = 32;   // CORDIC angle accumulator, 2^32 is one turn
    localparam int CORDIC_W = 36;   // CORDIC x and y registers
    localparam int CORDIC_STEPS = 30;
    localparam int RATIO_W  = 20;

    // Front pipeline depth and decoupling queue size.
    localparam int FRONT_STAGES = 3;
    localparam int QUEUE_DEPTH  = 8;

    // Gimbal lock is declared when sy * 10^6 < n.
    localparam logic [RATIO_W-1:0] SINGULAR_RATIO = 20'd1000000;

    localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
    localparam logic [TURN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] quat_w;
        logic signed [QUAT_WIDTH-1:0] quat_x;
        logic signed [QUAT_WIDTH-1:0] quat_y;
        logic signed [QUAT_WIDTH-1:0] quat_z;
    } quat_req_t;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] roll_angle;
        logic signed [ANGLE_WIDTH-1:0] pitch_angle;
        logic signed [ANGLE_WIDTH-1:0] yaw_angle;
        logic                          singular;
    } euler_res_t;

    // Block-scaled rotation matrix entries passed from front to back.
    typedef struct packed {
        logic [NORM_W-1:0]         norm;
        logic signed [ENTRY_W-1:0] r00;
        logic signed [ENTRY_W-1:0] r11;
        logic signed [ENTRY_W-1:0] r22;
        logic signed [ENTRY_W-1:0] r10;
        logic signed [ENTRY_W-1:0] r20;
        logic signed [ENTRY_W-1:0] r21;
        logic signed [ENTRY_W-1:0] r12;
    } matrix_t;

endpackage

/* sv/qte_front.sv */
module qte_front
    import qte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  quat_req_t request,
    output logic      out_valid,
    output matrix_t   out_matrix
);

    logic signed [COMP_W-1:0] cw, cx, cy, cz;

    // Reduce each component to its top sixteen bits.
    generate
        if (QUAT_WIDTH >= COMP_W) begin : g_wide
            assign cw = request.quat_w[QUAT_WIDTH-1 -: COMP_W];
            assign cx = request.quat_x[QUAT_WIDTH-1 -: COMP_W];
            assign cy = request.quat_y[QUAT_WIDTH-1 -: COMP_W];
            assign cz = request.quat_z[QUAT_WIDTH-1 -: COMP_W];
        end
        else begin : g_narrow
            assign cw = COMP_W'(request.quat_w);
            assign cx = COMP_W'(request.quat_x);
            assign cy = COMP_W'(request.quat_y);
            assign cz = COMP_W'(request.quat_z);
        end
    endgenerate

    logic signed [PROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [SUM_W-1:0]  n_reg, r00_reg, r11_reg, r22_reg;
    logic signed [SUM_W-1:0]  r10_reg, r20_reg, r21_reg, r12_reg;
    logic                     p_valid_reg, s_valid_reg, h_valid_reg;
    matrix_t                  matrix_reg;
    logic [1:0]               shamt;

    // Valid chain of the three front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= accept;
            s_valid_reg <= p_valid_reg;
            h_valid_reg <= s_valid_reg;
        end
    end

    // Stage one: the ten component products.
    always_ff @(posedge clk)
    begin
        ww_reg <= cw * cw;
        xx_reg <= cx * cx;
        yy_reg <= cy * cy;
        zz_reg <= cz * cz;
        xy_reg <= cx * cy;
        wz_reg <= cw * cz;
        xz_reg <= cx * cz;
        wy_reg <= cw * cy;
        yz_reg <= cy * cz;
        wx_reg <= cw * cx;
    end

    // Stage two: homogeneous matrix entries and the squared norm.
    always_ff @(posedge clk)
    begin
        n_reg   <= SUM_W'(ww_reg) + SUM_W'(xx_reg) + SUM_W'(yy_reg) + SUM_W'(zz_reg);
        r00_reg <= SUM_W'(ww_reg) + SUM_W'(xx_reg) - SUM_W'(yy_reg) - SUM_W'(zz_reg);
        r11_reg <= SUM_W'(ww_reg) - SUM_W'(xx_reg) + SUM_W'(yy_reg) - SUM_W'(zz_reg);
        r22_reg <= SUM_W'(ww_reg) - SUM_W'(xx_reg) - SUM_W'(yy_reg) + SUM_W'(zz_reg);
        r10_reg <= (SUM_W'(xy_reg) + SUM_W'(wz_reg)) <<< 1;
        r20_reg <= (SUM_W'(xz_reg) - SUM_W'(wy_reg)) <<< 1;
        r21_reg <= (SUM_W'(yz_reg) + SUM_W'(wx_reg)) <<< 1;
        r12_reg <= (SUM_W'(yz_reg) - SUM_W'(wx_reg)) <<< 1;
    end

    // The norm never exceeds 2^32, so at most three shifts bring it below 2^30.
    always_comb
    begin
        if (n_reg[32])
            shamt = 2'd3;
        else if (n_reg[31])
            shamt = 2'd2;
        else if (n_reg[30])
            shamt = 2'd1;
        else
            shamt = 2'd0;
    end

    // Stage three: block scaling with floor rounding.
    always_ff @(posedge clk)
    begin
        matrix_reg.norm <= NORM_W'(n_reg >>> shamt);
        matrix_reg.r00  <= ENTRY_W'(r00_reg >>> shamt);
        matrix_reg.r11  <= ENTRY_W'(r11_reg >>> shamt);
        matrix_reg.r22  <= ENTRY_W'(r22_reg >>> shamt);
        matrix_reg.r10  <= ENTRY_W'(r10_reg >>> shamt);
        matrix_reg.r20  <= ENTRY_W'(r20_reg >>> shamt);
        matrix_reg.r21  <= ENTRY_W'(r21_reg >>> shamt);
        matrix_reg.r12  <= ENTRY_W'(r12_reg >>> shamt);
    end

    assign out_valid  = h_valid_reg;
    assign out_matrix = matrix_reg;

endmodule

/* sv/qte_queue.sv */
module qte_queue
    import qte_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  matrix_t push_data,
    output logic    pop,
    output matrix_t pop_data,
    output logic    busy
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    matrix_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg, count_next;

    // The back end drains one entry every cycle that one is present.
    assign pop      = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Stop new requests while the front pipeline could overfill the queue.
    assign busy = (count_reg >= (PTR_W+1)'(QUEUE_DEPTH - FRONT_STAGES));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* sv/qte_isqrt.sv */
module qte_isqrt
    import qte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [SQ_W-1:0]   in_value,
    input  matrix_t           in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output matrix_t           out_side
);

    logic [SQ_W-1:0]   rem_src  [ROOT_W];
    logic [ROOT_W-1:0] root_src [ROOT_W];
    logic [SQ_W-1:0]   rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    matrix_t           side_reg [ROOT_W];
    logic              vld_reg  [ROOT_W];

    // One result bit per stage, most significant first.
    genvar j;
    generate
        for (j = 0; j < ROOT_W; j++)
        begin : g_stage
            localparam int K = ROOT_W - 1 - j;
            logic [SQ_W-1:0] trial;
            logic            take;

            if (j == 0)
            begin : g_first
                assign rem_src[j]  = in_value;
                assign root_src[j] = '0;
            end
            else
            begin : g_next
                assign rem_src[j]  = rem_reg[j-1];
                assign root_src[j] = root_reg[j-1];
            end

            // (r + 2^k)^2 - r^2 = r * 2^(k+1) + 2^(2k)
            assign trial = (SQ_W'(root_src[j]) << (K + 1)) + (SQ_W'(1) << (2 * K));
            assign take  = (rem_src[j] >= trial);

            always_ff @(posedge clk)
            begin
                rem_reg[j]  <= take ? rem_src[j] - trial : rem_src[j];
                root_reg[j] <= take ? root_src[j] | (ROOT_W'(1) << K) : root_src[j];
                side_reg[j] <= (j == 0) ? in_side : side_reg[(j == 0) ? 0 : j-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[j] <= 1'b0;
                else
                    vld_reg[j] <= (j == 0) ? in_valid : vld_reg[(j == 0) ? 0 : j-1];
            end
        end
    endgenerate

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

/* sv/qte_cordic.sv */
module qte_cordic
    import qte_pkg::*;
(
    input  logic                          clk,
    input  logic signed [ENTRY_W-1:0]     in_y,
    input  logic signed [ENTRY_W-1:0]     in_x,
    output logic signed [ANGLE_WIDTH-1:0] out_angle
);

    localparam int ROUND_SH = TURN_W - ANGLE_WIDTH;

    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS+1];
    logic [TURN_W-1:0]          z_reg [CORDIC_STEPS+1];
    logic                       zf_reg [CORDIC_STEPS+1];
    logic signed [ANGLE_WIDTH-1:0] angle_reg;
    logic [TURN_W-1:0]          z_round;

    // Fold the left half plane onto the right half plane.
    always_ff @(posedge clk)
    begin
        zf_reg[0] <= (in_x == '0) && (in_y == '0);
        if (in_x < 0)
        begin
            x_reg[0] <= -CORDIC_W'(in_x);
            y_reg[0] <= -CORDIC_W'(in_y);
            z_reg[0] <= HALF_TURN;
        end
        else
        begin
            x_reg[0] <= CORDIC_W'(in_x);
            y_reg[0] <= CORDIC_W'(in_y);
            z_reg[0] <= '0;
        end
    end

    // Vectoring iterations, one per stage.
    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            logic signed [CORDIC_W-1:0] dx, dy;
            assign dx = y_reg[i] >>> i;
            assign dy = x_reg[i] >>> i;

            always_ff @(posedge clk)
            begin
                zf_reg[i+1] <= zf_reg[i];
                if (y_reg[i] < 0)
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end
            end
        end
    endgenerate

    // Round to nearest at the output width, wrapping modulo one turn.
    generate
        if (ROUND_SH > 0)
        begin : g_round
            assign z_round = z_reg[CORDIC_STEPS] + (TURN_W'(1) << (ROUND_SH - 1));
        end
        else
        begin : g_exact
            assign z_round = z_reg[CORDIC_STEPS];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (zf_reg[CORDIC_STEPS])
            angle_reg <= '0;
        else
            angle_reg <= z_round[TURN_W-1 -: ANGLE_WIDTH];
    end

    assign out_angle = angle_reg;

endmodule

/* sv/qte_back.sv */
module qte_back
    import qte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  matrix_t    in_matrix,
    output logic       done,
    output euler_res_t result
);

    localparam int CORDIC_LAT = CORDIC_STEPS + 2;
    localparam int MAG_W      = ROOT_W + RATIO_W;

    logic signed [2*ENTRY_W-1:0] sq00_reg, sq10_reg;
    logic [SQ_W-1:0]             mag_reg;
    matrix_t                     m0_reg, m1_reg;
    logic                        v0_reg, v1_reg;

    logic                        root_valid;
    logic [ROOT_W-1:0]           root;
    matrix_t                     side;
    logic [MAG_W-1:0]            scaled_root;
    logic                        singular;

    logic signed [ENTRY_W-1:0]   pitch_y_reg, pitch_x_reg;
    logic signed [ENTRY_W-1:0]   roll_y_reg, roll_x_reg;
    logic signed [ENTRY_W-1:0]   yaw_y_reg, yaw_x_reg;
    logic                        sel_valid_reg, sel_sing_reg;
    logic                        vld_dly_reg  [CORDIC_LAT];
    logic                        sing_dly_reg [CORDIC_LAT];

    logic signed [ANGLE_WIDTH-1:0] roll, pitch, yaw;

    // Squares of the first column's top two entries.
    always_ff @(posedge clk)
    begin
        sq00_reg <= in_matrix.r00 * in_matrix.r00;
        sq10_reg <= in_matrix.r10 * in_matrix.r10;
        m0_reg   <= in_matrix;
        mag_reg  <= SQ_W'(sq00_reg) + SQ_W'(sq10_reg);
        m1_reg   <= m0_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    qte_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .in_value  (mag_reg),
        .in_side   (m1_reg),
        .out_valid (root_valid),
        .out_root  (root),
        .out_side  (side)
    );

    // Gimbal lock test: sy * 10^6 < n.
    assign scaled_root = MAG_W'(root) * MAG_W'(SINGULAR_RATIO);
    assign singular    = (scaled_root < MAG_W'(side.norm));

    // Choose the atan2 operands; a singular yaw gets a zero vector.
    always_ff @(posedge clk)
    begin
        pitch_y_reg  <= -side.r20;
        pitch_x_reg  <= ENTRY_W'(root);
        sel_sing_reg <= singular;
        if (singular)
        begin
            roll_y_reg <= -side.r12;
            roll_x_reg <= side.r11;
            yaw_y_reg  <= '0;
            yaw_x_reg  <= '0;
        end
        else
        begin
            roll_y_reg <= side.r21;
            roll_x_reg <= side.r22;
            yaw_y_reg  <= side.r10;
            yaw_x_reg  <= side.r00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_valid_reg <= 1'b0;
        else
            sel_valid_reg <= root_valid;
    end

    qte_cordic u_roll (
        .clk       (clk),
        .in_y      (roll_y_reg),
        .in_x      (roll_x_reg),
        .out_angle (roll)
    );

    qte_cordic u_pitch (
        .clk       (clk),
        .in_y      (pitch_y_reg),
        .in_x      (pitch_x_reg),
        .out_angle (pitch)
    );

    qte_cordic u_yaw (
        .clk       (clk),
        .in_y      (yaw_y_reg),
        .in_x      (yaw_x_reg),
        .out_angle (yaw)
    );

    // Strobe and flag follow the CORDIC latency.
    genvar d;
    generate
        for (d = 0; d < CORDIC_LAT; d++)
        begin : g_dly
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_dly_reg[d] <= 1'b0;
                else
                    vld_dly_reg[d] <= (d == 0) ? sel_valid_reg
                                               : vld_dly_reg[(d == 0) ? 0 : d-1];
            end

            always_ff @(posedge clk)
            begin
                sing_dly_reg[d] <= (d == 0) ? sel_sing_reg
                                            : sing_dly_reg[(d == 0) ? 0 : d-1];
            end
        end
    endgenerate

    assign done               = vld_dly_reg[CORDIC_LAT-1];
    assign result.roll_angle  = roll;
    assign result.pitch_angle = pitch;
    assign result.yaw_angle   = yaw;
    assign result.singular    = sing_dly_reg[CORDIC_LAT-1];

endmodule

/* sv/quaternion_to_euler_angles.sv */
// Channel    Ports                      Handshake
// ---------  -------------------------  ----------------------------------------
// request    start, busy, request       taken on a clock edge with start && !busy
// result     done, result               one-cycle strobe, cannot be held off
//
// One request is taken every cycle that busy is low; each passes through
// 3 front stages, the queue, 2 squaring stages, 30 square root stages,
// 1 select stage and 32 CORDIC stages. The 30-step root and CORDIC pipelines
// set the latency. Reset clears the valid chains and the queue pointers.
// busy rises only if the queue nears full; the back end never stalls, so in
// practice busy stays low.
module quaternion_to_euler_angles
    import qte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  quat_req_t  request,
    output logic       done,
    output euler_res_t result
);

    logic    front_valid;
    matrix_t front_matrix;
    logic    back_valid;
    matrix_t back_matrix;

    qte_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (start && !busy),
        .request    (request),
        .out_valid  (front_valid),
        .out_matrix (front_matrix)
    );

    qte_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_matrix),
        .pop       (back_valid),
        .pop_data  (back_matrix),
        .busy      (busy)
    );

    qte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (back_valid),
        .in_matrix (back_matrix),
        .done      (done),
        .result    (result)
    );

endmodule
